// ===== sv/swamm_pkg.sv =====
`timescale 1ns / 1ps

package swamm_pkg;

    localparam int WINDOW      = 128;
    localparam int SAMPLE_BITS = 16;

    localparam int FIELD_W = 16;
    localparam int HELD_W  = 8;
    localparam int FILL_W  = $clog2(WINDOW + 1);
    localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW);
    localparam int QCNT_W  = $clog2(SUM_W + 1);

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [FILL_W-1:0]      t_fill;
    typedef logic [SUM_W-1:0]       t_sum;

    typedef struct packed {
        t_sample lo;
        t_sample hi;
    } t_range;

    function automatic t_sample from_field(input logic [FIELD_W-1:0] v);
        t_sample r;
        r = '0;
        for (int b = 0; b < SAMPLE_BITS; b++) begin
            if (b < FIELD_W) begin
                r[b] = v[b];
            end
        end
        return r;
    endfunction

    function automatic logic [FIELD_W-1:0] sample_to_field(input t_sample v);
        logic [FIELD_W-1:0] r;
        r = '0;
        for (int b = 0; b < FIELD_W; b++) begin
            if (b < SAMPLE_BITS) begin
                r[b] = v[b];
            end
        end
        return r;
    endfunction

    function automatic logic [FIELD_W-1:0] sum_to_field(input t_sum v);
        logic [FIELD_W-1:0] r;
        r = '0;
        for (int b = 0; b < FIELD_W; b++) begin
            if (b < SUM_W) begin
                r[b] = v[b];
            end
        end
        return r;
    endfunction

    function automatic logic [HELD_W-1:0] fill_to_held(input t_fill v);
        logic [HELD_W-1:0] r;
        r = '0;
        for (int b = 0; b < HELD_W; b++) begin
            if (b < FILL_W) begin
                r[b] = v[b];
            end
        end
        return r;
    endfunction

endpackage

// ===== sv/swamm_cell.sv =====
`timescale 1ns / 1ps

module swamm_cell (
    input  logic               i_clk,
    input  logic               i_shift,
    input  swamm_pkg::t_sample i_data,
    output swamm_pkg::t_sample o_data,
    input  logic               i_active,
    input  swamm_pkg::t_range  i_range,
    output swamm_pkg::t_range  o_range
);

    swamm_pkg::t_sample r_data;
    swamm_pkg::t_range  r_range;
    swamm_pkg::t_range  n_range;

    always_comb begin
        n_range = i_range;
        if (i_active) begin
            if (r_data < i_range.lo) begin
                n_range.lo = r_data;
            end
            if (r_data > i_range.hi) begin
                n_range.hi = r_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_data;
        end
        r_range <= n_range;
    end

    assign o_data  = r_data;
    assign o_range = r_range;

endmodule

// ===== sv/swamm_div.sv =====
`timescale 1ns / 1ps

module swamm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  swamm_pkg::t_sum   i_num,
    input  swamm_pkg::t_fill  i_den,
    output logic              o_busy,
    output swamm_pkg::t_sum   o_quo
);

    localparam int FW = swamm_pkg::FILL_W;
    localparam int SW = swamm_pkg::SUM_W;
    localparam int CW = swamm_pkg::QCNT_W;

    logic              r_busy;
    logic [CW-1:0]     r_cnt;
    logic [FW-1:0]     r_rem;
    logic [SW-1:0]     r_quo;
    logic [FW-1:0]     r_den;
    logic [FW:0]       w_shift;
    logic [FW:0]       w_diff;
    logic              w_ge;

    assign w_shift = {r_rem, r_quo[SW-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_ge    = w_shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(SW);
            r_rem  <= '0;
            r_quo  <= i_num;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[FW-1:0] : w_shift[FW-1:0];
            r_quo <= {r_quo[SW-2:0], w_ge};
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule

// ===== sv/sliding_window_avg_min_max_unit.sv =====
`timescale 1ns / 1ps

// sliding window average, minimum and maximum of a rate sample (1/64 units)
// input channel: i_valid, i_sample, o_stall; a word is taken when i_valid is
// high and o_stall is low
// output channel: o_valid, o_current, o_average, o_minimum, o_maximum, o_held;
// a word leaves when o_valid is high and i_stall is low
// samples sit in a row of cells that shifts once per word; min and max ripple
// through the row one cell per cycle while a restoring divider forms the
// average one quotient bit per cycle alongside
// the result is loaded into the output register once the min/max sweep counter
// has run down and the divider is no longer busy; one word is in work at a
// time, so no further word is taken until the result of the last one is loaded
// o_stall stays high from acceptance until the result is loaded into the
// output register; a new word is taken while that result still waits
// if i_stall holds the previous result, loading of the next one waits
// reset clears the fill count, running sum and valid; old samples are ignored
module sliding_window_avg_min_max_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [15:0] i_sample,
    output logic        o_stall,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_current,
    output logic [15:0] o_average,
    output logic [15:0] o_minimum,
    output logic [15:0] o_maximum,
    output logic [7:0]  o_held
);

    localparam int W  = swamm_pkg::WINDOW;
    localparam int FW = swamm_pkg::FILL_W;
    localparam int CW = $clog2(W + 1);

    typedef enum logic {
        ST_IDLE,
        ST_SWEEP
    } t_state;

    t_state               r_state;
    logic [CW-1:0]        r_cnt;
    swamm_pkg::t_fill     r_fill;
    swamm_pkg::t_sum      r_sum;
    swamm_pkg::t_sample   r_cur;
    logic                 r_valid;
    logic [15:0]          r_current;
    logic [15:0]          r_average;
    logic [15:0]          r_minimum;
    logic [15:0]          r_maximum;
    logic [7:0]           r_held;

    swamm_pkg::t_fill     n_fill;
    swamm_pkg::t_sum      n_sum;
    swamm_pkg::t_sample   w_s;
    swamm_pkg::t_sample   w_data  [W];
    swamm_pkg::t_range    w_range [W];
    swamm_pkg::t_range    w_seed;
    logic                 w_full;
    logic                 w_acc;
    logic                 w_load;
    logic                 w_div_busy;
    swamm_pkg::t_sum      w_quo;

    assign w_s    = swamm_pkg::from_field(i_sample);
    assign w_acc  = i_valid && (r_state == ST_IDLE);
    assign w_full = (r_fill == FW'(W));
    assign n_fill = w_full ? r_fill : r_fill + 1'b1;
    assign n_sum  = r_sum + swamm_pkg::t_sum'(w_s)
                    - (w_full ? swamm_pkg::t_sum'(w_data[W-1]) : '0);
    assign w_seed.lo = '1;
    assign w_seed.hi = '0;

    assign w_load = (r_state == ST_SWEEP) && (r_cnt == '0) && !w_div_busy
                    && !(r_valid && i_stall);

    // sample row
    for (genvar g = 0; g < W; g++) begin : g_cell
        swamm_cell u_cell (
            .i_clk    (i_clk),
            .i_shift  (w_acc),
            .i_data   ((g == 0) ? w_s : w_data[(g == 0) ? 0 : g - 1]),
            .o_data   (w_data[g]),
            .i_active (FW'(g) < r_fill),
            .i_range  ((g == 0) ? w_seed : w_range[(g == 0) ? 0 : g - 1]),
            .o_range  (w_range[g])
        );
    end

    swamm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_acc),
        .i_num   (n_sum),
        .i_den   (n_fill),
        .o_busy  (w_div_busy),
        .o_quo   (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_fill  <= '0;
            r_sum   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && !i_stall && !w_load) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        r_fill  <= n_fill;
                        r_sum   <= n_sum;
                        r_cur   <= w_s;
                        r_cnt   <= CW'(W);
                        r_state <= ST_SWEEP;
                    end
                end
                ST_SWEEP: begin
                    if (r_cnt != '0) begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                    if (w_load) begin
                        r_valid   <= 1'b1;
                        r_current <= swamm_pkg::sample_to_field(r_cur);
                        r_average <= swamm_pkg::sum_to_field(w_quo);
                        r_minimum <= swamm_pkg::sample_to_field(w_range[W-1].lo);
                        r_maximum <= swamm_pkg::sample_to_field(w_range[W-1].hi);
                        r_held    <= swamm_pkg::fill_to_held(r_fill);
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_stall   = (r_state != ST_IDLE);
    assign o_valid   = r_valid;
    assign o_current = r_current;
    assign o_average = r_average;
    assign o_minimum = r_minimum;
    assign o_maximum = r_maximum;
    assign o_held    = r_held;

endmodule

// ===== tb/sliding_window_avg_min_max_unit_test.sv =====
`timescale 1ns / 1ps

module sliding_window_avg_min_max_unit_test;

    localparam int WIN          = swamm_pkg::WINDOW;
    localparam int SUM_BITS     = swamm_pkg::SUM_W;
    localparam int FILL_BITS    = swamm_pkg::FILL_W;
    localparam int RANDOM_ITEMS = 750;
    localparam int TAIL_CYCLES  = WIN + SUM_BITS + 16;
    localparam int N_DIRECTED   = 22;

    typedef struct packed {
        logic [15:0] current;
        logic [15:0] average;
        logic [15:0] minimum;
        logic [15:0] maximum;
        logic [7:0]  held;
    } t_stats;

    typedef struct packed {
        logic [15:0] sample;
        logic        typed;
        t_stats      want;
    } t_stim_row;

    typedef enum int {
        SEG_UNIFORM,
        SEG_LOW,
        SEG_HIGH,
        SEG_EXTREME,
        SEG_RAMP,
        SEG_FLAT
    } t_seg_kind;

    localparam t_stats NO_STATS = '0;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        i_valid  = 1'b0;
    logic [15:0] i_sample = 16'h0000;
    logic        i_stall  = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [15:0] o_current;
    logic [15:0] o_average;
    logic [15:0] o_minimum;
    logic [15:0] o_maximum;
    logic [7:0]  o_held;

    sliding_window_avg_min_max_unit DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_sample  (i_sample),
        .o_stall   (o_stall),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_current (o_current),
        .o_average (o_average),
        .o_minimum (o_minimum),
        .o_maximum (o_maximum),
        .o_held    (o_held)
    );

    always #5 i_clk = ~i_clk;

    // window predictor state
    logic [15:0]          win_samples [WIN];
    logic [FILL_BITS-1:0] win_count = '0;
    int                   win_oldest = 0;
    logic [SUM_BITS-1:0]  win_sum = '0;

    t_stats pending_stats [$];
    int     mismatch_count = 0;
    bit     send_calm = 1'b0;
    int     stall_left = 0;
    int     calm_left = 0;

    t_stim_row directed_rows [N_DIRECTED] = '{
        '{16'h0000, 1'b1, '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'd1}},
        '{16'hFFFF, 1'b1, '{16'hFFFF, 16'h7FFF, 16'h0000, 16'hFFFF, 8'd2}},
        '{16'hFFFF, 1'b1, '{16'hFFFF, 16'hAAAA, 16'h0000, 16'hFFFF, 8'd3}},
        '{16'h0001, 1'b1, '{16'h0001, 16'h7FFF, 16'h0000, 16'hFFFF, 8'd4}},
        '{16'h8000, 1'b0, NO_STATS},
        '{16'h7FFF, 1'b0, NO_STATS},
        '{16'h5555, 1'b0, NO_STATS},
        '{16'hAAAA, 1'b0, NO_STATS},
        '{16'h0040, 1'b0, NO_STATS},
        '{16'h00FF, 1'b0, NO_STATS},
        '{16'hFF00, 1'b0, NO_STATS},
        '{16'h0F0F, 1'b0, NO_STATS},
        '{16'hF0F0, 1'b0, NO_STATS},
        '{16'h1234, 1'b0, NO_STATS},
        '{16'hEDCB, 1'b0, NO_STATS},
        '{16'hFFFE, 1'b0, NO_STATS},
        '{16'h0002, 1'b0, NO_STATS},
        '{16'h3333, 1'b0, NO_STATS},
        '{16'hCCCC, 1'b0, NO_STATS},
        '{16'h0000, 1'b0, NO_STATS},
        '{16'hFFFF, 1'b0, NO_STATS},
        '{16'h0100, 1'b0, NO_STATS}
    };

    function automatic t_stats window_stats_step(input logic [15:0] s);
        t_stats              r;
        int                  slot;
        logic [15:0]         v;
        logic [15:0]         lo;
        logic [15:0]         hi;
        logic [SUM_BITS-1:0] quotient;
        if (win_count < WIN) begin
            slot = (win_oldest + int'(win_count)) % WIN;
            win_samples[slot] = s;
            win_count = win_count + 1'b1;
            win_sum = win_sum + s;
        end else begin
            win_sum = win_sum - win_samples[win_oldest] + s;
            win_samples[win_oldest] = s;
            win_oldest = (win_oldest + 1) % WIN;
        end
        lo = s;
        hi = s;
        for (int i = 0; i < int'(win_count); i++) begin
            v = win_samples[(win_oldest + i) % WIN];
            if (v < lo) begin
                lo = v;
            end
            if (v > hi) begin
                hi = v;
            end
        end
        quotient = win_sum / win_count;
        r.current = s;
        r.average = quotient[15:0];
        r.minimum = lo;
        r.maximum = hi;
        r.held    = 8'(win_count);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (send_calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 100);
    endfunction

    task automatic send_sample(input logic [15:0] s, input logic typed, input t_stats want);
        t_stats predicted;
        int     gap;
        i_sample <= s;
        i_valid  <= 1'b1;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        predicted = window_stats_step(s);
        pending_stats.insert(pending_stats.size(), typed ? want : predicted);
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_pending();
        i_valid <= 1'b0;
        while (pending_stats.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("mismatch %s: expected %h, got %h", name, want, got);
            end
        end
    endtask

    // result side: check accepted words and drive stall
    always @(posedge i_clk) begin
        t_stats want;
        int     r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_stats.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected word: current %h average %h min %h max %h held %0d",
                             o_current, o_average, o_minimum, o_maximum, o_held);
                end
            end else begin
                want = pending_stats.pop_front();
                check_field("current", want.current, o_current);
                check_field("average", want.average, o_average);
                check_field("minimum", want.minimum, o_minimum);
                check_field("maximum", want.maximum, o_maximum);
                check_field("held", {8'h00, want.held}, {8'h00, o_held});
            end
        end
        if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else if (calm_left > 0) begin
            i_stall <= 1'b0;
            calm_left--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                calm_left = $urandom_range(100, 600);
                i_stall <= 1'b0;
            end else if (r < 50) begin
                i_stall <= 1'b0;
            end else if (r < 96) begin
                stall_left = $urandom_range(0, 3);
                i_stall <= 1'b1;
            end else begin
                stall_left = $urandom_range(20, 100);
                i_stall <= 1'b1;
            end
        end
    end

    initial begin
        int          random_count;
        int          seg_len;
        int          stepv;
        bit          paused;
        bit          rising;
        t_seg_kind   kind;
        logic [15:0] base;
        logic [15:0] s;
        for (int i = 0; i < WIN; i++) begin
            win_samples[i] = 16'h0000;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_sample(directed_rows[i].sample, directed_rows[i].typed, directed_rows[i].want);
        end

        random_count = 0;
        paused = 1'b0;
        while (random_count < RANDOM_ITEMS) begin
            kind      = t_seg_kind'($urandom_range(0, 5));
            seg_len   = $urandom_range(1, 160);
            base      = 16'($urandom);
            stepv     = $urandom_range(0, 600);
            rising    = 1'($urandom);
            send_calm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < seg_len && random_count < RANDOM_ITEMS; k++) begin
                case (kind)
                    SEG_UNIFORM: begin
                        s = 16'($urandom);
                    end
                    SEG_LOW: begin
                        s = 16'($urandom_range(0, 255));
                    end
                    SEG_HIGH: begin
                        s = 16'($urandom_range(16'hFF00, 16'hFFFF));
                    end
                    SEG_EXTREME: begin
                        s = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    end
                    SEG_RAMP: begin
                        s = rising ? base + 16'(k * stepv) : base - 16'(k * stepv);
                    end
                    default: begin
                        s = base;
                    end
                endcase
                send_sample(s, 1'b0, NO_STATS);
                random_count++;
                if (!paused && random_count >= RANDOM_ITEMS / 2) begin
                    paused = 1'b1;
                    drain_pending();
                end
            end
        end

        drain_pending();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_stats.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
